FILE: rtl/mft_pkg.sv
// Shared types, constants and the 5x8 font for the framebuffer text engine.
// No dependencies.
`timescale 1ns / 1ps
package mft_pkg;
	localparam int ScreenWidth  = 128;
	localparam int ScreenHeight = 64;
	localparam int QueueDepth   = 2;

	typedef enum logic [2:0] {
		FUNC_FILL   = 3'd0,
		FUNC_PIXEL  = 3'd1,
		FUNC_CURSOR = 3'd2,
		FUNC_CHAR   = 3'd3,
		FUNC_STRING = 3'd4,
		FUNC_READ   = 3'd5
	} func_e;

	localparam logic [0:0] RegTextScale = 1'b0;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] character;
		logic       color;
		logic       string_start;
		logic [9:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic       status;
		logic [7:0] read_byte;
	} out_item_t;

	// Glyph column c of character code, fallback to '?'.
	function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] c);
		logic [5:0]  g;
		logic [39:0] row;
		logic [7:0]  k;
		begin
			k = (code < 8'd32 || code > 8'd90) ? 8'd63 : code;
			g = 6'(k - 8'd32);
			case (g)
				6'd0:  row = 40'h0000000000; 6'd1:  row = 40'h00005F0000;
				6'd2:  row = 40'h0007000700; 6'd3:  row = 40'h147F147F14;
				6'd4:  row = 40'h242A7F2A12; 6'd5:  row = 40'h2313086462;
				6'd6:  row = 40'h3649552250; 6'd7:  row = 40'h0005030000;
				6'd8:  row = 40'h001C224100; 6'd9:  row = 40'h0041221C00;
				6'd10: row = 40'h14083E0814; 6'd11: row = 40'h08083E0808;
				6'd12: row = 40'h0050300000; 6'd13: row = 40'h0808080808;
				6'd14: row = 40'h0060600000; 6'd15: row = 40'h2010080402;
				6'd16: row = 40'h3E5149453E; 6'd17: row = 40'h00427F4000;
				6'd18: row = 40'h4261514946; 6'd19: row = 40'h2141454B31;
				6'd20: row = 40'h1814127F10; 6'd21: row = 40'h2745454539;
				6'd22: row = 40'h3C4A494930; 6'd23: row = 40'h0171090503;
				6'd24: row = 40'h3649494936; 6'd25: row = 40'h064949291E;
				6'd26: row = 40'h0036360000; 6'd27: row = 40'h0056360000;
				6'd28: row = 40'h0814224100; 6'd29: row = 40'h1414141414;
				6'd30: row = 40'h0041221408; 6'd31: row = 40'h0201510906;
				6'd32: row = 40'h324979413E; 6'd33: row = 40'h7E1111117E;
				6'd34: row = 40'h7F49494936; 6'd35: row = 40'h3E41414122;
				6'd36: row = 40'h7F4141221C; 6'd37: row = 40'h7F49494941;
				6'd38: row = 40'h7F09090901; 6'd39: row = 40'h3E4149497A;
				6'd40: row = 40'h7F0808087F; 6'd41: row = 40'h00417F4100;
				6'd42: row = 40'h2040413F01; 6'd43: row = 40'h7F08142241;
				6'd44: row = 40'h7F40404040; 6'd45: row = 40'h7F020C027F;
				6'd46: row = 40'h7F0408107F; 6'd47: row = 40'h3E4141413E;
				6'd48: row = 40'h7F09090906; 6'd49: row = 40'h3E4151215E;
				6'd50: row = 40'h7F09192946; 6'd51: row = 40'h4649494931;
				6'd52: row = 40'h01017F0101; 6'd53: row = 40'h3F4040403F;
				6'd54: row = 40'h1F2040201F; 6'd55: row = 40'h3F4038403F;
				6'd56: row = 40'h6314081463; 6'd57: row = 40'h0708700807;
				6'd58: row = 40'h6151494543;
				default: row = 40'h0;
			endcase
			case (c)
				3'd0: glyph_col = row[39:32];
				3'd1: glyph_col = row[31:24];
				3'd2: glyph_col = row[23:16];
				3'd3: glyph_col = row[15:8];
				3'd4: glyph_col = row[7:0];
				default: glyph_col = 8'h00;
			endcase
		end
	endfunction
endpackage

FILE: rtl/mono_framebuffer_text_engine.sv
// Top level of the monochrome framebuffer text engine: APB register, front queue, back end.
// Depends on mft_pkg, mft_front, mft_back.
//
//  channel | signals                       | payload
//  in      | in_valid / in_ready           | in_data (in_item_t)
//  out     | out_valid / out_ready         | out_data (out_item_t)
//  cfg     | psel penable pwrite paddr ... | text_scale at 0x0
//
// After reset the framebuffer is cleared, one byte a cycle, all W*H/8 bytes (1024
// by default), before any item is taken. Each drawn glyph pixel is a read-modify-write;
// clipped pixels, and unset ones in a string, are skipped without a write. A stalled
// output holds the back end in place; up to two items wait in the front queue meanwhile.
`timescale 1ns / 1ps
module mono_framebuffer_text_engine #(
	parameter int SCREEN_WIDTH  = mft_pkg::ScreenWidth,
	parameter int SCREEN_HEIGHT = mft_pkg::ScreenHeight
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mft_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mft_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mft_pkg::*;

	logic       q_valid, q_pop;
	in_item_t   q_data;
	logic [3:0] scale_q, wv;

	assign pready = 1'b1;
	assign wv = pwdata[3:0];
	assign prdata = (paddr[1:0] == 2'd0) ? {28'd0, scale_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 4'd1;
		end else if (psel && penable && pwrite && paddr == {RegTextScale, 1'b0}) begin
			scale_q <= (wv == 4'd0) ? 4'd1 : (wv > 4'd10) ? 4'd10 : wv;
		end
	end

	mft_front #(.QDepth(QueueDepth)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	mft_back #(.ScrW(SCREEN_WIDTH), .ScrH(SCREEN_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.scale(scale_q), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

FILE: rtl/mft_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mft_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: rtl/mft_front.sv
// Front end: accepts command items into a short queue.
// Depends on mft_pkg.
`timescale 1ns / 1ps
module mft_front #(
	parameter int QDepth = mft_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mft_pkg::in_item_t in_data,
	output logic              q_valid,
	input  logic              q_pop,
	output mft_pkg::in_item_t q_data
);
	import mft_pkg::*;
	localparam int Aw = (QDepth > 1) ? $clog2(QDepth) : 1;

	in_item_t         fifo_q [QDepth];
	logic [Aw-1:0]    wr_q, rd_q;
	logic [Aw:0]      cnt_q;
	logic             push;

	assign in_ready = (cnt_q != (Aw+1)'(QDepth));
	assign q_valid  = (cnt_q != '0);
	assign q_data   = fifo_q[rd_q];
	assign push     = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Aw'(QDepth-1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == Aw'(QDepth-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(q_pop);
		end
	end
endmodule

FILE: rtl/mft_back.sv
// Back end: carries out commands against the framebuffer RAM; pixels and glyphs by read-modify-write.
// Depends on mft_pkg and mft_ram.
`timescale 1ns / 1ps
module mft_back #(
	parameter int ScrW = mft_pkg::ScreenWidth,
	parameter int ScrH = mft_pkg::ScreenHeight
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  mft_pkg::in_item_t  q_data,
	input  logic [3:0]         scale,
	output logic               out_valid,
	input  logic               out_ready,
	output mft_pkg::out_item_t out_data
);
	import mft_pkg::*;
	localparam int Bytes = ScrW * ScrH / 8;
	localparam int Aw    = $clog2(Bytes);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_FILL, ST_PREP, ST_RD, ST_WAIT, ST_WR, ST_READ_WAIT,
		ST_READ_DONE, ST_OUT
	} state_t;

	state_t         state_q;
	in_item_t       item_q;
	logic [Aw:0]    fill_q;
	logic [7:0]     ccol_q, crow_q, sorg_q, scol_q, srow_q;
	logic           sstop_q;
	// pixel walk: glyph column c, glyph row r, block offsets dx, dy
	logic [2:0]     c_q, r_q;
	logic [3:0]     dx_q, dy_q;
	logic [8:0]     bx_q, by_q;   // pixel, string or char base
	logic           opaque_q;     // write-char mode
	logic [3:0]     s_q;
	logic [9:0]     px, py;
	logic           pix_on, pix_white, single_q;
	logic [Aw-1:0]  addr_q;
	logic [2:0]     bit_q;
	logic           wval_q;
	logic           ram_we;
	logic [Aw-1:0]  ram_addr;
	logic [7:0]     ram_wdata, ram_rdata;
	logic [7:0]     line;
	logic [7:0]     s6, s8;

	mft_ram #(.Width(8), .Depth(Bytes)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign line = glyph_col(item_q.character, c_q);
	// c*s + dx ; s <= 10, c <= 5
	assign px = 10'(bx_q) + 10'(c_q) * 10'(s_q) + 10'(dx_q);
	assign py = 10'(by_q) + 10'(r_q) * 10'(s_q) + 10'(dy_q);
	assign pix_on    = opaque_q ? 1'b1 : line[r_q];
	assign pix_white = opaque_q ? (line[r_q] ? item_q.color : !item_q.color) : item_q.color;
	assign s6 = 8'(scale) * 8'd6;
	assign s8 = 8'(scale) * 8'd8;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = wval_q ? (ram_rdata | (8'd1 << bit_q)) : (ram_rdata & ~(8'd1 << bit_q));
		case (state_q)
			ST_CLEAR, ST_FILL: begin
				ram_we    = 1'b1;
				ram_addr  = fill_q[Aw-1:0];
				ram_wdata = (state_q == ST_FILL && item_q.color) ? 8'hFF : 8'h00;
			end
			ST_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			fill_q <= '0;
			ccol_q <= '0; crow_q <= '0; sorg_q <= '0; scol_q <= '0; srow_q <= '0;
			sstop_q <= 1'b0;
			item_q <= '0; out_data <= '0;
			c_q <= '0; r_q <= '0; dx_q <= '0; dy_q <= '0; bx_q <= '0; by_q <= '0;
			opaque_q <= 1'b0; s_q <= 4'd1; single_q <= 1'b0;
			addr_q <= '0; bit_q <= '0; wval_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR, ST_FILL: begin
					if (fill_q == (Aw+1)'(Bytes-1)) begin
						fill_q  <= '0;
						state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_OUT;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_IDLE: if (q_valid) begin
					item_q   <= q_data;
					c_q <= '0; r_q <= '0; dx_q <= '0; dy_q <= '0;
					single_q <= (q_data.func == FUNC_PIXEL);
					case (q_data.func)
						FUNC_FILL: state_q <= ST_FILL;
						FUNC_PIXEL: begin
							opaque_q <= 1'b0; s_q <= 4'd1;
							bx_q <= 9'(q_data.pos_x); by_q <= 9'(q_data.pos_y);
							state_q <= ST_PREP;
						end
						FUNC_CURSOR: begin
							ccol_q <= q_data.pos_x; crow_q <= q_data.pos_y;
							state_q <= ST_OUT;
						end
						FUNC_CHAR: begin
							if (9'(ccol_q) + 9'd6 >= 9'(ScrW) ||
							    9'(crow_q) + 9'd8 >= 9'(ScrH)) begin
								out_data.status <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								opaque_q <= 1'b1; s_q <= 4'd1;
								bx_q <= 9'(ccol_q); by_q <= 9'(crow_q);
								ccol_q <= ccol_q + 8'd6;
								state_q <= ST_PREP;
							end
						end
						FUNC_STRING: begin
							logic [7:0] col, row, org;
							logic       stop;
							col = q_data.string_start ? q_data.pos_x : scol_q;
							row = q_data.string_start ? q_data.pos_y : srow_q;
							org = q_data.string_start ? q_data.pos_x : sorg_q;
							stop = q_data.string_start ? 1'b0 : sstop_q;
							// wrap to the string's origin column, stop once the new line reaches the bottom edge
							if (!stop && (9'(col) + 9'(s6) >= 9'(ScrW))) begin
								col = org;
								row = row + s8;
								if (9'(row) + 9'(s8) >= 9'(ScrH)) stop = 1'b1;
							end
							sorg_q  <= org;
							sstop_q <= stop;
							srow_q  <= row;
							if (stop) begin
								out_data.status <= 1'b1;
								scol_q  <= col;
								state_q <= ST_OUT;
							end else begin
								opaque_q <= 1'b0; s_q <= scale;
								bx_q <= 9'(col); by_q <= 9'(row);
								scol_q <= col + s6;
								state_q <= ST_PREP;
							end
						end
						FUNC_READ: begin
							addr_q  <= Aw'(q_data.read_index);
							state_q <= (int'(q_data.read_index) < Bytes) ?
								ST_READ_WAIT : ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_PREP: begin
					// one pixel of the walk; skip clipped or unset ones
					if ((single_q || pix_on) && px < 10'(ScrW) && py < 10'(ScrH)) begin
						addr_q <= Aw'(32'(py[9:3]) * ScrW + 32'(px));
						bit_q  <= py[2:0];
						wval_q <= single_q ? item_q.color : pix_white;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: state_q <= ST_WAIT;
				ST_WAIT: begin
					// advance dy, dx, r, c
					if (single_q) begin
						state_q <= ST_OUT;
					end else if (dy_q != s_q - 4'd1 && pix_on) begin
						dy_q <= dy_q + 1'b1;
						state_q <= ST_PREP;
					end else begin
						dy_q <= '0;
						if (dx_q != s_q - 4'd1 && pix_on) begin
							dx_q <= dx_q + 1'b1;
							state_q <= ST_PREP;
						end else begin
							dx_q <= '0;
							if (r_q != (opaque_q ? 3'd7 : 3'd6)) begin
								r_q <= r_q + 1'b1;
								state_q <= ST_PREP;
							end else begin
								r_q <= '0;
								if (c_q != (opaque_q ? 3'd5 : 3'd4)) begin
									c_q <= c_q + 1'b1;
									state_q <= ST_PREP;
								end else begin
									state_q <= ST_OUT;
								end
							end
						end
					end
				end
				ST_READ_WAIT: state_q <= ST_READ_DONE;
				ST_READ_DONE: begin
					out_data.read_byte <= ram_rdata;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) begin
					out_data <= '0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
